/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the RTL of the key table search.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define KTS_ASSERT(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

// The condition must never be seen at a rising edge outside reset.
`define KTS_ASSERT_NEVER(label, clk_sig, rst_n_sig, cond, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) !(cond)) \
		else $error(msg);

`endif

/* hdl/kts_pkg.sv */
// ----------------------------------------------------------------------------
// kts_pkg
// Shared widths, codes and types of the key table search.
// ----------------------------------------------------------------------------
`default_nettype none

package kts_pkg;

	localparam int KTS_DEPTH  = 32;
	localparam int KIND_W     = 2;
	localparam int POS_W      = 6;
	localparam int KEY_W      = 32;
	localparam int CNT_W      = 6;
	localparam int APB_ADDR_W = 2;
	localparam int APB_DATA_W = 32;

	localparam logic [CNT_W-1:0]      CNT_RESET        = CNT_W'(32);
	localparam logic [APB_ADDR_W-1:0] ADDR_ENTRY_COUNT = '0;

	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SEQ   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BIN   = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CHECK,
		ST_FINISH
	} state_t;

	// Outcome of the shared key comparator.
	typedef struct packed {
		logic eq;
		logic gt;
	} cmp_res_t;

endpackage

`default_nettype wire

/* hdl/kts_if.sv */
// ----------------------------------------------------------------------------
// kts_if
// Valid/ready channels of the key table search: requests in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface kts_item_if;
	logic                                valid;
	logic                                ready;
	logic [kts_pkg::KIND_W-1:0]          kind;
	logic [kts_pkg::POS_W-1:0]           position;
	logic signed [kts_pkg::KEY_W-1:0]    key_value;

	modport source (output valid, kind, position, key_value, input ready);
	modport sink   (input valid, kind, position, key_value, output ready);
endinterface

interface kts_result_if;
	logic                        valid;
	logic                        ready;
	logic [kts_pkg::POS_W-1:0]   found_position;

	modport source (output valid, found_position, input ready);
	modport sink   (input valid, found_position, output ready);
endinterface

`default_nettype wire

/* hdl/kts_ram.sv */
// ----------------------------------------------------------------------------
// kts_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* hdl/kts_cmp.sv */
// ----------------------------------------------------------------------------
// kts_cmp
// Shared key comparator: equality and signed greater-than of entry vs key.
// ----------------------------------------------------------------------------
`default_nettype none

module kts_cmp (
	input  wire logic signed [kts_pkg::KEY_W-1:0] entry,
	input  wire logic signed [kts_pkg::KEY_W-1:0] key,
	output kts_pkg::cmp_res_t                     res
);

	assign res.eq = (entry == key);
	assign res.gt = (entry > key);

endmodule

`default_nettype wire

/* hdl/kts_engine.sv */
// ----------------------------------------------------------------------------
// kts_engine
// Sequencer that owns the key RAM and runs both searches through one
// comparator, one RAM read per probe.
// ----------------------------------------------------------------------------
`default_nettype none

module kts_engine #(
	parameter int DEPTH = kts_pkg::KTS_DEPTH
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic [kts_pkg::CNT_W-1:0]          entry_count,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [kts_pkg::KIND_W-1:0]         in_kind,
	input  wire logic [kts_pkg::POS_W-1:0]          in_position,
	input  wire logic signed [kts_pkg::KEY_W-1:0]   in_key,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [kts_pkg::POS_W-1:0]               out_position
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// Probe positions run 0..DEPTH+1 (low may pass high by one).
	localparam int PW    = $clog2(DEPTH + 2);
	localparam int CMP_W = (PW > kts_pkg::POS_W) ? PW : kts_pkg::POS_W;

	kts_pkg::state_t state_q, state_d;

	logic [PW-1:0]                   pos_q, pos_d;
	logic [PW-1:0]                   low_q, low_d;
	logic [PW-1:0]                   high_q, high_d;
	logic [PW-1:0]                   res_q, res_d;
	logic                            bin_q;
	logic signed [kts_pkg::KEY_W-1:0] key_q;
	logic                            out_valid_q;
	logic [kts_pkg::POS_W-1:0]       out_pos_q;

	logic                            accept;
	logic                            rd_en;
	logic                            wr_en;
	logic [IDX_W-1:0]                rd_addr;
	logic [IDX_W-1:0]                wr_addr;
	logic signed [kts_pkg::KEY_W-1:0] rd_data;
	kts_pkg::cmp_res_t               cmp;

	logic [CMP_W-1:0]                cnt_ext;
	logic [CMP_W-1:0]                wpos_ext;
	logic [CMP_W-1:0]                wpos_m1;
	logic [CMP_W-1:0]                res_ext;
	logic [PW-1:0]                   active;
	logic [PW-1:0]                   mid;
	logic [PW-1:0]                   pos_m1;
	logic                            wpos_ok;
	logic                            out_free;

	// Count above DEPTH saturates to DEPTH.
	assign cnt_ext  = CMP_W'(entry_count);
	assign active   = (cnt_ext > CMP_W'(DEPTH)) ? PW'(DEPTH) : cnt_ext[PW-1:0];

	assign wpos_ext = CMP_W'(in_position);
	assign wpos_ok  = (wpos_ext != '0) && (wpos_ext <= CMP_W'(DEPTH));
	assign wpos_m1  = wpos_ext - CMP_W'(1);
	assign wr_addr  = wpos_m1[IDX_W-1:0];

	assign mid      = low_q + ((high_q - low_q) >> 1);
	assign pos_m1   = pos_d - PW'(1);
	assign rd_addr  = pos_m1[IDX_W-1:0];

	assign in_ready = (state_q == kts_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	kts_ram #(
		.WIDTH (kts_pkg::KEY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (in_key),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	kts_cmp u_cmp (
		.entry (rd_data),
		.key   (key_q),
		.res   (cmp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kts_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == kts_pkg::ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q  <= pos_d;
		low_q  <= low_d;
		high_q <= high_d;
		res_q  <= res_d;
		if (accept) begin
			key_q <= in_key;
			bin_q <= (in_kind == kts_pkg::KIND_BIN);
		end
		if (state_q == kts_pkg::ST_FINISH && out_free) begin
			out_pos_q <= res_ext[kts_pkg::POS_W-1:0];
		end
	end

	assign res_ext = CMP_W'(res_q);

	// The RAM is read at pos_d, so the data seen in CHECK belongs to pos_q.
	always_comb begin
		state_d = state_q;
		pos_d   = pos_q;
		low_d   = low_q;
		high_d  = high_q;
		res_d   = res_q;
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		case (state_q)
			kts_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (in_kind)
						kts_pkg::KIND_WRITE: begin
							wr_en = wpos_ok;
						end
						kts_pkg::KIND_SEQ: begin
							if (active == '0) begin
								res_d   = '0;
								state_d = kts_pkg::ST_FINISH;
							end else begin
								pos_d   = active;
								rd_en   = 1'b1;
								state_d = kts_pkg::ST_CHECK;
							end
						end
						kts_pkg::KIND_BIN: begin
							low_d   = PW'(1);
							high_d  = active;
							state_d = kts_pkg::ST_PROBE;
						end
						default: begin
							state_d = kts_pkg::ST_IDLE;
						end
					endcase
				end
			end
			kts_pkg::ST_PROBE: begin
				if (low_q > high_q) begin
					res_d   = '0;
					state_d = kts_pkg::ST_FINISH;
				end else begin
					pos_d   = mid;
					rd_en   = 1'b1;
					state_d = kts_pkg::ST_CHECK;
				end
			end
			kts_pkg::ST_CHECK: begin
				if (cmp.eq) begin
					res_d   = pos_q;
					state_d = kts_pkg::ST_FINISH;
				end else if (!bin_q) begin
					if (pos_q == PW'(1)) begin
						res_d   = '0;
						state_d = kts_pkg::ST_FINISH;
					end else begin
						pos_d = pos_q - PW'(1);
						rd_en = 1'b1;
					end
				end else begin
					if (cmp.gt) begin
						high_d = pos_q - PW'(1);
					end else begin
						low_d = pos_q + PW'(1);
					end
					state_d = kts_pkg::ST_PROBE;
				end
			end
			kts_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = kts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = kts_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign out_position = out_pos_q;

endmodule

`default_nettype wire

/* hdl/key_table_search.sv */
// ----------------------------------------------------------------------------
// key_table_search
// Key table with a sequential and a binary search, one RAM read per probe.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake      | payload
//  item     | in  | valid / ready  | kind, position, key_value
//  result   | out | valid / ready  | found_position
//  apb      | in  | psel / penable | entry_count at byte address 0
//
// A write or an unused kind leaves the request side ready. A sequential
// search scans down from the last entry through at most entry_count
// entries. A binary search alternates PROBE and CHECK, ending in PROBE when
// none matches. A waiting result stalls only the next search to complete.
// Reset clears control state only; the table holds no data until written.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module key_table_search #(
	parameter int DEPTH = kts_pkg::KTS_DEPTH
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [kts_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [kts_pkg::APB_DATA_W-1:0]     pwdata,
	output logic      [kts_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                    pready,
	kts_item_if.sink                                item,
	kts_result_if.source                            result
);

	logic [kts_pkg::CNT_W-1:0] entry_count_q;
	logic                      cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == kts_pkg::ADDR_ENTRY_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= kts_pkg::CNT_RESET;
		end else if (cfg_wr) begin
			entry_count_q <= pwdata[kts_pkg::CNT_W-1:0];
		end
	end

	assign prdata = (paddr == kts_pkg::ADDR_ENTRY_COUNT) ?
		kts_pkg::APB_DATA_W'(entry_count_q) : '0;

	kts_engine #(
		.DEPTH (DEPTH)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.entry_count  (entry_count_q),
		.in_valid     (item.valid),
		.in_ready     (item.ready),
		.in_kind      (item.kind),
		.in_position  (item.position),
		.in_key       (item.key_value),
		.out_valid    (result.valid),
		.out_ready    (result.ready),
		.out_position (result.found_position)
	);

	`KTS_ASSERT(a_cnt_only_by_apb, clk, arst_n, !(psel && penable && pwrite) |=> $stable(entry_count_q), "entry_count changed without an APB write")
	`KTS_ASSERT(a_search_busy, clk, arst_n, (item.valid && item.ready && (item.kind == kts_pkg::KIND_SEQ || item.kind == kts_pkg::KIND_BIN)) |=> !item.ready, "accepted search did not occupy the engine")
	`KTS_ASSERT(a_write_no_stall, clk, arst_n, (item.valid && item.ready && item.kind == kts_pkg::KIND_WRITE) |=> item.ready, "table write stalled the request side")
	`KTS_ASSERT_NEVER(a_result_range, clk, arst_n, result.valid && (int'(result.found_position) > DEPTH), "found position beyond table depth")

endmodule

`default_nettype wire
